[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAU_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, operation codes and divider handshake types.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int VB  = 64;
  localparam int DW  = VB - 1;
  localparam int W2  = 2 * VB;
  localparam int CW  = $clog2(W2);

  localparam logic [VB-1:0] VMAX_V = {1'b0, {DW{1'b1}}};
  localparam logic [W2-1:0] VMAX_W = {{(W2 - DW){1'b0}}, {DW{1'b1}}};

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MOD = 3'd4
  } mode_e;

  typedef struct packed {
    logic          start;
    logic [W2-1:0] dividend;
    logic [W2-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [W2-1:0] quot;
    logic [W2-1:0] rem;
  } div_rsp_t;

endpackage

[hdl/rau_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Operation code and two rational operands.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic signed [VB-1:0] left_num;
  logic [DW-1:0]        left_den;
  logic signed [VB-1:0] right_num;
  logic [DW-1:0]        right_den;

  modport source (output valid, mode, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink   (input valid, mode, left_num, left_den, right_num, right_den,
                  output ready);
endinterface

[hdl/rau_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Reduced rational result and overflow status.
// ----------------------------------------------------------------------------
interface rau_rsp_if import rau_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [VB-1:0] result_num;
  logic [DW-1:0]        result_den;
  logic                 status;

  modport source (output valid, result_num, result_den, status, input ready);
  modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

[hdl/rau_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle over the double-wide word.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W2-1:0] dv_q, dd_q, rr_q;
  logic [W2:0]   sh, diff;
  logic          ge;

  assign sh   = {rr_q, dv_q[W2-1]};
  assign diff = sh - {1'b0, dd_q};
  assign ge   = sh >= {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W2 - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dv_q <= req_i.dividend;
      dd_q <= req_i.divisor;
      rr_q <= '0;
    end else if (busy_q) begin
      rr_q <= ge ? diff[W2-1:0] : sh[W2-1:0];
      dv_q <= {dv_q[W2-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dv_q;
  assign rsp_o.rem  = rr_q;

endmodule

[hdl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide and truncating modulo of rationals.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries mode and two operands num/den (den 0: NaN, +inf, -inf).
//   rsp_o returns one reduced result per request beat, plus overflow status.
//   One item is in flight at a time; req_i.ready is high while the sequencer
//   is idle, even when a finished result still waits in the output register.
//   Special operands go straight to S_DONE. Otherwise up to 3 bit-serial
//   products (one multiplier bit per cycle, stops when the bits run out),
//   a binary GCD (one shift or subtract per cycle), and 2 or 3 passes of the
//   serial divider. A zero result skips the GCD and the reducing divides
//   and comes back after the products (and the modulo pass).
//   A new request is taken only after the sequencer has handed on its result.
//   A stalled rsp_o holds its beat; the next result waits in the sequencer
//   until the output register frees up.
//   Reset clears the sequencer and the output valid; no memory to clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_unit import rau_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  rau_req_if.sink   req_i,
  rau_rsp_if.source rsp_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MLOAD   = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_COMB    = 4'd3;
  localparam logic [3:0] S_FIN     = 4'd4;
  localparam logic [3:0] S_GTWO    = 4'd5;
  localparam logic [3:0] S_GSTRIP  = 4'd6;
  localparam logic [3:0] S_GLOOP   = 4'd7;
  localparam logic [3:0] S_GSHL    = 4'd8;
  localparam logic [3:0] S_DLAUNCH = 4'd9;
  localparam logic [3:0] S_DWAIT   = 4'd10;
  localparam logic [3:0] S_CHK     = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  localparam logic [1:0] D_MOD = 2'd0;
  localparam logic [1:0] D_NUM = 2'd1;
  localparam logic [1:0] D_DEN = 2'd2;

  logic [3:0]    state_q, state_d;
  logic [1:0]    k_q, k_d, dsel_q, dsel_d;
  logic [CW-1:0] sh_q, sh_d;
  logic          ovalid_q, ovalid_d;
  mode_e         mode_q, mode_d;
  logic          lneg_q, lneg_d, rneg_q, rneg_d, neg_q, neg_d;
  logic [VB-1:0] lmag_q, lmag_d, rmag_q, rmag_d;
  logic [DW-1:0] lden_q, lden_d, rden_q, rden_d;
  logic [W2-1:0] mx_q, mx_d, acc_q, acc_d;
  logic [VB-1:0] my_q, my_d;
  logic [W2-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [W2-1:0] nn_q, nn_d, dn_q, dn_d, ga_q, ga_d, gb_q, gb_d;
  logic [VB-1:0] rnum_q, rnum_d;
  logic [DW-1:0] rden_r_q, rden_r_d;
  logic          rst_q, rst_d;
  logic [VB-1:0] onum_q, onum_d;
  logic [DW-1:0] oden_q, oden_d;
  logic          ost_q, ost_d;

  logic          in_lneg, in_rneg, early;
  logic [VB-1:0] in_lmag, in_rmag, e_num;
  logic          e_st;
  logic [W2-1:0] op_x;
  logic [VB-1:0] op_y;
  logic [1:0]    last_k;
  logic          bneg;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_lneg = req_i.left_num[VB-1];
  assign in_rneg = req_i.right_num[VB-1];
  assign in_lmag = in_lneg ? (~req_i.left_num + 1'b1) : req_i.left_num;
  assign in_rmag = in_rneg ? (~req_i.right_num + 1'b1) : req_i.right_num;

  always_comb begin
    early = 1'b1;
    e_num = '0;
    e_st  = 1'b0;
    priority if (req_i.mode > MODE_MOD) begin
      e_num = '0;
    end else if (in_lmag > VMAX_V || in_rmag > VMAX_V ||
                 VB'(req_i.left_den) > VMAX_V || VB'(req_i.right_den) > VMAX_V) begin
      e_st = 1'b1;
    end else if (req_i.left_den == '0 || req_i.right_den == '0) begin
      e_num = '0;
    end else if (req_i.mode >= MODE_DIV && in_rmag == '0) begin
      if (in_lmag != '0) e_num = in_lneg ? '1 : VB'(1);
    end else begin
      early = 1'b0;
    end
  end

  always_comb begin
    op_x = W2'(lden_q);
    op_y = VB'(rden_q);
    unique case (k_q)
      2'd0: begin
        op_x = W2'(lmag_q);
        op_y = (mode_q == MODE_MUL) ? rmag_q : VB'(rden_q);
      end
      2'd1: op_y = (mode_q == MODE_MUL) ? VB'(rden_q) : rmag_q;
      default: op_y = VB'(rden_q);
    endcase
  end

  assign last_k = (mode_q == MODE_MUL || mode_q == MODE_DIV) ? 2'd1 : 2'd2;
  assign bneg   = rneg_q ^ (mode_q == MODE_SUB);

  always_comb begin
    div_req.start    = (state_q == S_DLAUNCH);
    div_req.dividend = p0_q;
    div_req.divisor  = p1_q;
    unique case (dsel_q)
      D_NUM: begin
        div_req.dividend = nn_q;
        div_req.divisor  = ga_q;
      end
      D_DEN: begin
        div_req.dividend = dn_q;
        div_req.divisor  = ga_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    dsel_d   = dsel_q;
    sh_d     = sh_q;
    ovalid_d = ovalid_q;
    mode_d   = mode_q;
    lneg_d   = lneg_q;
    rneg_d   = rneg_q;
    neg_d    = neg_q;
    lmag_d   = lmag_q;
    rmag_d   = rmag_q;
    lden_d   = lden_q;
    rden_d   = rden_q;
    mx_d     = mx_q;
    my_d     = my_q;
    acc_d    = acc_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    nn_d     = nn_q;
    dn_d     = dn_q;
    ga_d     = ga_q;
    gb_d     = gb_q;
    rnum_d   = rnum_q;
    rden_r_d = rden_r_q;
    rst_d    = rst_q;
    onum_d   = onum_q;
    oden_d   = oden_q;
    ost_d    = ost_q;

    if (rsp_o.ready) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d = mode_e'(req_i.mode);
          lneg_d = in_lneg;
          rneg_d = in_rneg;
          lmag_d = in_lmag;
          rmag_d = in_rmag;
          lden_d = req_i.left_den;
          rden_d = req_i.right_den;
          k_d    = 2'd0;
          if (early) begin
            rnum_d   = e_num;
            rden_r_d = '0;
            rst_d    = e_st;
            state_d  = S_DONE;
          end else begin
            state_d = S_MLOAD;
          end
        end
      end
      S_MLOAD: begin
        mx_d    = op_x;
        my_d    = op_y;
        acc_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (my_q == '0) begin
          unique case (k_q)
            2'd0:    p0_d = acc_q;
            2'd1:    p1_d = acc_q;
            default: p2_d = acc_q;
          endcase
          if (k_q == last_k) begin
            if (mode_q == MODE_MOD) begin
              dsel_d  = D_MOD;
              state_d = S_DLAUNCH;
            end else begin
              state_d = S_COMB;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_MLOAD;
          end
        end else begin
          if (my_q[0]) acc_d = acc_q + mx_q;
          mx_d = {mx_q[W2-2:0], 1'b0};
          my_d = {1'b0, my_q[VB-1:1]};
        end
      end
      S_COMB: begin
        state_d = S_FIN;
        if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
          dn_d = p2_q;
          if (lneg_q == bneg) begin
            nn_d  = p0_q + p1_q;
            neg_d = lneg_q;
          end else if (p0_q >= p1_q) begin
            nn_d  = p0_q - p1_q;
            neg_d = lneg_q;
          end else begin
            nn_d  = p1_q - p0_q;
            neg_d = bneg;
          end
        end else begin
          nn_d  = p0_q;
          dn_d  = p1_q;
          neg_d = lneg_q ^ rneg_q;
        end
      end
      S_FIN: begin
        if (nn_q == '0) begin
          rnum_d   = '0;
          rden_r_d = DW'(1);
          rst_d    = 1'b0;
          state_d  = S_DONE;
        end else begin
          ga_d    = nn_q;
          gb_d    = dn_q;
          sh_d    = '0;
          state_d = S_GTWO;
        end
      end
      S_GTWO: begin
        if (!(ga_q[0] | gb_q[0])) begin
          ga_d = {1'b0, ga_q[W2-1:1]};
          gb_d = {1'b0, gb_q[W2-1:1]};
          sh_d = sh_q + 1'b1;
        end else begin
          state_d = S_GSTRIP;
        end
      end
      S_GSTRIP: begin
        if (!ga_q[0]) ga_d = {1'b0, ga_q[W2-1:1]};
        else          state_d = S_GLOOP;
      end
      S_GLOOP: begin
        priority if (gb_q == '0) begin
          state_d = S_GSHL;
        end else if (!gb_q[0]) begin
          gb_d = {1'b0, gb_q[W2-1:1]};
        end else if (gb_q >= ga_q) begin
          gb_d = gb_q - ga_q;
        end else begin
          ga_d = gb_q;
          gb_d = ga_q - gb_q;
        end
      end
      S_GSHL: begin
        if (sh_q != '0) begin
          ga_d = {ga_q[W2-2:0], 1'b0};
          sh_d = sh_q - 1'b1;
        end else begin
          dsel_d  = D_NUM;
          state_d = S_DLAUNCH;
        end
      end
      S_DLAUNCH: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          unique case (dsel_q)
            D_MOD: begin
              nn_d    = div_rsp.rem;
              dn_d    = p2_q;
              neg_d   = lneg_q;
              state_d = S_FIN;
            end
            D_NUM: begin
              nn_d    = div_rsp.quot;
              dsel_d  = D_DEN;
              state_d = S_DLAUNCH;
            end
            default: begin
              dn_d    = div_rsp.quot;
              state_d = S_CHK;
            end
          endcase
        end
      end
      S_CHK: begin
        state_d = S_DONE;
        if (nn_q > VMAX_W || dn_q > VMAX_W) begin
          rnum_d   = '0;
          rden_r_d = '0;
          rst_d    = 1'b1;
        end else begin
          rnum_d   = neg_q ? (~nn_q[VB-1:0] + 1'b1) : nn_q[VB-1:0];
          rden_r_d = dn_q[DW-1:0];
          rst_d    = 1'b0;
        end
      end
      S_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          onum_d   = rnum_q;
          oden_d   = rden_r_q;
          ost_d    = rst_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      dsel_q   <= D_MOD;
      sh_q     <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      dsel_q   <= dsel_d;
      sh_q     <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    lneg_q   <= lneg_d;
    rneg_q   <= rneg_d;
    neg_q    <= neg_d;
    lmag_q   <= lmag_d;
    rmag_q   <= rmag_d;
    lden_q   <= lden_d;
    rden_q   <= rden_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    acc_q    <= acc_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    nn_q     <= nn_d;
    dn_q     <= dn_d;
    ga_q     <= ga_d;
    gb_q     <= gb_d;
    rnum_q   <= rnum_d;
    rden_r_q <= rden_r_d;
    rst_q    <= rst_d;
    onum_q   <= onum_d;
    oden_q   <= oden_d;
    ost_q    <= ost_d;
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.result_num = onum_q;
  assign rsp_o.result_den = oden_q;
  assign rsp_o.status     = ost_q;

  `RAU_ASSERT(a_ovf_zero, clk_i, rst_ni,
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.result_num == '0 && rsp_o.result_den == '0),
    "overflow beat carries nonzero fields")
  `RAU_ASSERT(a_nonfinite, clk_i, rst_ni,
    (rsp_o.valid && !rsp_o.status && rsp_o.result_den == '0) |->
      (rsp_o.result_num == '0 || rsp_o.result_num == VB'(1) || rsp_o.result_num == '1),
    "non-finite result not canonical")
  `RAU_NEVER(a_div_restart, clk_i, rst_ni, div_req.start && div_rsp.busy,
    "divider restarted while busy")
  `RAU_ASSERT(a_gcd_odd, clk_i, rst_ni, (state_q == S_GLOOP) |-> ga_q[0],
    "gcd operand lost oddness")

endmodule
